FILE: rtl/pcxrle_pkg.sv
package pcxrle_pkg;

  localparam int ByteW   = 8;
  localparam int CntW    = 6;
  localparam int ColW    = 18;
  localparam int RowW    = 16;
  localparam int WidthW  = 16;
  localparam int HeightW = 16;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LINE_BYTES   = 2'd2;

  localparam logic [ByteW-1:0] RUN_MARK   = 8'hc0;
  localparam logic [ByteW-1:0] COUNT_MASK = 8'h3f;

  typedef struct packed {
    logic load;
    logic emit;
  } pcxrle_cmd_t;

  typedef struct packed {
    logic start;
    logic emit_last;
    logic img_end;
  } pcxrle_status_t;

endpackage

FILE: rtl/pcxrle_dp.sv
module pcxrle_dp import pcxrle_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [ColW-1:0]     cfg_data,
  input  logic [ByteW-1:0]    byte_in,
  input  pcxrle_cmd_t         cmd,
  output pcxrle_status_t      status,
  output logic [ByteW-1:0]    pixel_value,
  output logic [ColW-1:0]     column,
  output logic [RowW-1:0]     row,
  output logic                is_pixel,
  output logic                last_of_run,
  output logic                image_done
);

  logic [WidthW-1:0]  image_width;
  logic [HeightW-1:0] image_height;
  logic [ColW-1:0]    line_bytes;
  logic               await_run_value;
  logic [CntW-1:0]    pending_count;
  logic [CntW-1:0]    remaining;
  logic [ByteW-1:0]   run_value;
  logic [ColW-1:0]    column_pos;
  logic [RowW-1:0]    row_pos;

  logic               is_header;
  logic [ColW:0]      col_inc;
  logic [RowW:0]      row_inc;
  logic               line_end;
  logic               img_end;

  assign is_header = (byte_in & RUN_MARK) == RUN_MARK;
  assign col_inc   = {1'b0, column_pos} + {{ColW{1'b0}}, 1'b1};
  assign row_inc   = {1'b0, row_pos} + {{RowW{1'b0}}, 1'b1};
  assign line_end  = col_inc >= {1'b0, line_bytes};
  assign img_end   = line_end && (row_inc >= {1'b0, image_height});

  assign status.start     = await_run_value ? (pending_count != '0) : !is_header;
  assign status.emit_last = (remaining == {{(CntW-1){1'b0}}, 1'b1}) || img_end;
  assign status.img_end   = img_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= {{(WidthW-1){1'b0}}, 1'b1};
      image_height    <= {{(HeightW-1){1'b0}}, 1'b1};
      line_bytes      <= {{(ColW-1){1'b0}}, 1'b1};
      await_run_value <= 1'b0;
      pending_count   <= '0;
      remaining       <= '0;
      column_pos      <= '0;
      row_pos         <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WidthW-1:0];
          CFG_IMAGE_HEIGHT: image_height <= cfg_data[HeightW-1:0];
          CFG_LINE_BYTES:   line_bytes   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (await_run_value) begin
          await_run_value <= 1'b0;
          remaining       <= pending_count;
          pending_count   <= '0;
        end else if (is_header) begin
          await_run_value <= 1'b1;
          pending_count   <= CntW'(byte_in & COUNT_MASK);
        end else begin
          remaining <= {{(CntW-1){1'b0}}, 1'b1};
        end
      end
      if (cmd.emit) begin
        remaining <= remaining - {{(CntW-1){1'b0}}, 1'b1};
        if (line_end) begin
          column_pos <= '0;
          row_pos    <= row_inc[RowW-1:0];
        end else begin
          column_pos <= col_inc[ColW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run_value <= byte_in;
    end
    if (cmd.emit) begin
      pixel_value <= run_value;
      column      <= column_pos;
      row         <= row_pos;
      is_pixel    <= {{(ColW-WidthW){1'b0}}, image_width} > column_pos;
      last_of_run <= status.emit_last;
      image_done  <= img_end;
    end
  end

endmodule

FILE: rtl/pcxrle_ctrl.sv
module pcxrle_ctrl import pcxrle_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pcxrle_status_t status,
  output pcxrle_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  assign in_ready       = (state == S_IDLE) || (state == S_DONE);
  assign cmd.load       = in_valid && (state == S_IDLE);
  assign cmd.emit       = (state == S_EMIT) && (!out_valid || out_ready);
  assign out_valid_next = cmd.emit || (out_valid && !out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load && status.start) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd.emit && status.emit_last) begin
          state_next = status.img_end ? S_DONE : S_IDLE;
        end
      end
      S_DONE: state_next = S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_emit_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> state == S_EMIT)
    else $error("emit issued outside the emit state");

  a_no_emit_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.emit)
    else $error("output register overwritten while stalled");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> state == S_DONE && !cmd.load)
    else $error("decoder left the finished state");

  a_done_after_end: assert property (@(posedge clk) disable iff (rst)
    (state != S_DONE) ##1 (state == S_DONE) |-> $past(cmd.emit && status.img_end))
    else $error("finished state entered without the image end");

endmodule

FILE: rtl/pcx_rle_scanline_decoder_core.sv
// PCX run-length decoder for eight bit image data, with line and row tracking.
// Encoded bytes enter one at a time on in_valid/in_ready as byte_in. A byte
// with both top bits set is a run header, and the following byte is repeated
// as many times as its low six bits give; any other byte is a literal.
// Each decoded byte leaves on out_valid/out_ready with its column, row, a
// pixel flag (column below image_width) and flags for the last byte of the
// item and for the byte that completes the image.
// Configuration is written on cfg_valid/cfg_ready (always ready): index 0
// image_width, 1 image_height, 2 line_bytes. The user must write it only while
// idle; the block itself does not enforce this. A literal is accepted while idle
// and its byte is placed in the output register from the emit state. A run header
// is accepted alone; its value byte then yields one decoded byte per cycle unless
// the receiver stalls, through the single emit port of the output register.
// Reset clears the decoding state and sets all three registers to one.
// When the receiver stalls, the output register holds and decoding pauses.
// After the image is complete, items are accepted and dropped until reset.
module pcx_rle_scanline_decoder_core import pcxrle_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ColW-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ByteW-1:0]   byte_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ByteW-1:0]   pixel_value,
  output logic [ColW-1:0]    column,
  output logic [RowW-1:0]    row,
  output logic               is_pixel,
  output logic               last_of_run,
  output logic               image_done
);

  pcxrle_cmd_t    cmd;
  pcxrle_status_t status;

  assign cfg_ready = 1'b1;

  pcxrle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pcxrle_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_in     (byte_in),
    .cmd         (cmd),
    .status      (status),
    .pixel_value (pixel_value),
    .column      (column),
    .row         (row),
    .is_pixel    (is_pixel),
    .last_of_run (last_of_run),
    .image_done  (image_done)
  );

endmodule
